// File: src/i2c_master_bit_sequencer_core_macros.svh
// assertion macros shared by the i2c master bit sequencer rtl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define I2CM_ASSERT(label, clk, rst_n, prop, msg)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/i2cm_pkg.sv
// shared types and constants for the i2c master bit sequencer
// used by i2cm_seq, i2cm_out_reg and the top level
package i2cm_pkg;

    localparam int UNIT_COUNT_WIDTH_DEF = 16;
    localparam int UNIT_TICKS_W         = 16;
    localparam int ACK_TIMEOUT_W        = 10;
    localparam int CFG_INDEX_W          = 1;
    localparam int CFG_DATA_W           = 16;
    localparam int IN_TDATA_W           = 16;
    localparam int OUT_TDATA_W          = 16;

    localparam logic [UNIT_TICKS_W-1:0]  UNIT_TICKS_RESET  = 16'd16;
    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 10'd250;

    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TICKS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } t_result;

endpackage

// File: src/i2cm_seq.sv
// bus sequencing state machine: one tick per word, config registers
// depends on i2cm_pkg and i2c_master_bit_sequencer_core_macros.svh
`include "i2c_master_bit_sequencer_core_macros.svh"

module i2cm_seq #(
    parameter int UNIT_COUNT_WIDTH = i2cm_pkg::UNIT_COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_fire,
    input  i2cm_pkg::t_item                   i_item,
    output i2cm_pkg::t_result                 o_result
);
    import i2cm_pkg::*;

    localparam int DW = UNIT_COUNT_WIDTH + 2;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_SP_C    = 4'd5;
    localparam logic [3:0] PH_WA_POLL = 4'd6;
    localparam logic [3:0] PH_WR_DATA = 4'd7;
    localparam logic [3:0] PH_WR_HIGH = 4'd8;
    localparam logic [3:0] PH_WR_LOW  = 4'd9;
    localparam logic [3:0] PH_RD_LOW  = 4'd10;
    localparam logic [3:0] PH_RD_HIGH = 4'd11;
    localparam logic [3:0] PH_AK_LOW  = 4'd12;
    localparam logic [3:0] PH_AK_HIGH = 4'd13;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_WAIT  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    logic [UNIT_TICKS_W-1:0]  r_unit_ticks;
    logic [ACK_TIMEOUT_W-1:0] r_ack_timeout;

    logic [3:0]               r_phase, n_phase;
    logic [3:0]               r_bit_count, n_bit_count;
    logic [7:0]               r_shift, n_shift;
    logic [DW-1:0]            r_delay, n_delay;
    logic [ACK_TIMEOUT_W-1:0] r_poll, n_poll;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_sda_dir, n_sda_dir;
    logic                     r_ack_choice, n_ack_choice;
    logic [7:0]               r_rx, n_rx;
    logic                     r_ack_fail, n_ack_fail;
    logic                     n_done;

    logic [UNIT_COUNT_WIDTH-1:0] w_ut;
    logic [UNIT_COUNT_WIDTH-1:0] w_u1;
    logic [DW-1:0]               w_units1, w_units2, w_units4;
    logic [3:0]                  w_bit_inc;
    logic [7:0]                  w_rd_shift;

    // unit length masked to the counter width, zero taken as one tick
    always_comb begin
        for (int i = 0; i < UNIT_COUNT_WIDTH; i++) begin
            w_ut[i] = (i < UNIT_TICKS_W) ? r_unit_ticks[i % UNIT_TICKS_W] : 1'b0;
        end
    end

    assign w_u1       = (w_ut == '0) ? UNIT_COUNT_WIDTH'(1) : w_ut;
    assign w_units1   = {2'b00, w_u1};
    assign w_units2   = {1'b0, w_u1, 1'b0};
    assign w_units4   = {w_u1, 2'b00};
    assign w_bit_inc  = r_bit_count + 4'd1;
    assign w_rd_shift = {r_shift[6:0], i_item.sda_sample};

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_poll       = r_poll;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_dir    = r_sda_dir;
        n_ack_choice = r_ack_choice;
        n_rx         = r_rx;
        n_ack_fail   = r_ack_fail;
        n_done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_item.cmd_valid) begin
                unique case (i_item.command)
                    CMD_START: begin
                        n_sda_dir = 1'b1;
                        n_sda     = 1'b1;
                        n_scl     = 1'b1;
                        n_phase   = PH_ST_A;
                        n_delay   = w_units4;
                    end
                    CMD_STOP: begin
                        n_sda_dir = 1'b1;
                        n_scl     = 1'b0;
                        n_sda     = 1'b0;
                        n_phase   = PH_SP_A;
                        n_delay   = w_units4;
                    end
                    CMD_WRITE: begin
                        n_sda_dir   = 1'b1;
                        n_scl       = 1'b0;
                        n_bit_count = 4'd0;
                        n_sda       = i_item.tx_byte[7];
                        n_shift     = {i_item.tx_byte[6:0], 1'b0};
                        n_phase     = PH_WR_DATA;
                        n_delay     = w_units2;
                    end
                    CMD_WAIT: begin
                        n_sda_dir = 1'b0;
                        n_sda     = 1'b1;
                        n_scl     = 1'b1;
                        n_poll    = '0;
                        n_phase   = PH_WA_POLL;
                        n_delay   = '0;
                    end
                    CMD_READ: begin
                        n_sda_dir    = 1'b0;
                        n_scl        = 1'b0;
                        n_bit_count  = 4'd0;
                        n_shift      = 8'd0;
                        n_ack_choice = i_item.send_ack;
                        n_phase      = PH_RD_LOW;
                        n_delay      = w_units2;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_phase == PH_WA_POLL) begin
            priority if (!i_item.sda_sample) begin
                n_scl      = 1'b0;
                n_ack_fail = 1'b0;
                n_phase    = PH_IDLE;
                n_delay    = '0;
                n_done     = 1'b1;
            end else if (r_poll >= r_ack_timeout) begin
                n_ack_fail = 1'b1;
                n_sda_dir  = 1'b1;
                n_scl      = 1'b0;
                n_sda      = 1'b0;
                n_phase    = PH_SP_A;
                n_delay    = w_units4;
            end else begin
                n_poll = r_poll + ACK_TIMEOUT_W'(1);
            end
        end else if (r_delay > DW'(1)) begin
            n_delay = r_delay - DW'(1);
        end else begin
            unique case (r_phase)
                PH_ST_A: begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_B;
                    n_delay = w_units4;
                end
                PH_ST_B: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_delay = '0;
                    n_done  = 1'b1;
                end
                PH_SP_A: begin
                    n_scl   = 1'b1;
                    n_phase = PH_SP_B;
                    n_delay = DW'(1);
                end
                PH_SP_B: begin
                    n_sda   = 1'b1;
                    n_phase = PH_SP_C;
                    n_delay = w_units4;
                end
                PH_SP_C: begin
                    n_phase = PH_IDLE;
                    n_delay = '0;
                    n_done  = 1'b1;
                end
                PH_WR_DATA: begin
                    n_scl   = 1'b1;
                    n_phase = PH_WR_HIGH;
                    n_delay = w_units2;
                end
                PH_WR_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_WR_LOW;
                    n_delay = w_units2;
                end
                PH_WR_LOW: begin
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_phase = PH_IDLE;
                        n_delay = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_WR_DATA;
                        n_delay = w_units2;
                    end
                end
                PH_RD_LOW: begin
                    n_scl       = 1'b1;
                    n_shift     = w_rd_shift;
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc >= 4'd8) begin
                        n_rx = w_rd_shift;
                    end
                    n_phase = PH_RD_HIGH;
                    n_delay = w_units1;
                end
                PH_RD_HIGH: begin
                    n_scl = 1'b0;
                    if (r_bit_count >= 4'd8) begin
                        n_sda_dir = 1'b1;
                        n_sda     = ~r_ack_choice;
                        n_phase   = PH_AK_LOW;
                        n_delay   = w_units2;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_delay = w_units2;
                    end
                end
                PH_AK_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_AK_HIGH;
                    n_delay = w_units2;
                end
                PH_AK_HIGH: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_delay = '0;
                    n_done  = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_delay = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_TICKS_RESET;
            r_ack_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_UNIT_TICKS) begin
                r_unit_ticks <= i_cfg_data[UNIT_TICKS_W-1:0];
            end
            if (i_cfg_index == REG_ACK_TIMEOUT) begin
                r_ack_timeout <= i_cfg_data[ACK_TIMEOUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_delay      <= '0;
            r_poll       <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_dir    <= 1'b1;
            r_ack_choice <= 1'b0;
            r_rx         <= 8'd0;
            r_ack_fail   <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_poll       <= n_poll;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_dir    <= n_sda_dir;
            r_ack_choice <= n_ack_choice;
            r_rx         <= n_rx;
            r_ack_fail   <= n_ack_fail;
        end
    end

    // result reflects the state after this word's update
    always_comb begin
        o_result.scl_level   = n_scl;
        o_result.sda_level   = n_sda;
        o_result.sda_drive   = n_sda_dir;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = n_done;
        o_result.rx_byte     = n_rx;
        o_result.ack_missing = n_ack_fail;
    end

    `I2CM_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n, i_fire && n_done, r_phase == PH_IDLE, "completion did not return to idle")
    `I2CM_ASSERT(a_poll_released, i_clk, i_rst_n, (r_phase == PH_WA_POLL) |-> (!r_sda_dir && r_scl), "ack poll with sda driven or scl low")
    `I2CM_ASSERT(a_bit_count_range, i_clk, i_rst_n, r_bit_count <= 4'd8, "bit count beyond one byte")
    `I2CM_ASSERT_NEXT(a_busy_hold, i_clk, i_rst_n, !i_fire && (r_phase != PH_IDLE), $stable(r_phase) && $stable(r_delay), "sequencer moved without a word")

endmodule

// File: src/i2cm_out_reg.sv
// result register holding one word until the downstream side takes it
// depends on i2cm_pkg
module i2cm_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  i2cm_pkg::t_result i_data,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output i2cm_pkg::t_result o_data
);
    import i2cm_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
        end
    end

endmodule

// File: src/i2c_master_bit_sequencer_core.sv
// channel    | dir | handshake                     | payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready | s_axis_tdata, 14 bits used
// m_axis     | out | m_axis_tvalid / m_axis_tready | m_axis_tdata, 14 bits used
// cfg        | in  | i_cfg_we                      | i_cfg_index, i_cfg_data
// one word accepted per cycle when the result side keeps up
// a word is registered in the input register, its result then in the output register
// m_axis_tvalid comes from the output register and holds until the result is taken
// the single-pass step in i2cm_seq sets the rate: one word per clock when the result side keeps up
// synchronous active-low reset; the user must write config only with nothing in flight, the block does not enforce it
// a stalled result holds the input register and then s_axis_tready
module i2c_master_bit_sequencer_core #(
    parameter int UNIT_COUNT_WIDTH = i2cm_pkg::UNIT_COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd_valid, command[3], tx_byte[8], send_ack, sda_sample, zero pad
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte[8], ack_missing, zero pad
    output logic [i2cm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import i2cm_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    t_item   w_item;
    t_result w_step_res;
    t_result w_out_res;
    logic    w_can_load;
    logic    w_fire;

    assign w_item.cmd_valid  = s_axis_tdata[0];
    assign w_item.command    = s_axis_tdata[3:1];
    assign w_item.tx_byte    = s_axis_tdata[11:4];
    assign w_item.send_ack   = s_axis_tdata[12];
    assign w_item.sda_sample = s_axis_tdata[13];

    assign w_fire        = r_in_valid && w_can_load;
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= w_item;
        end
    end

    i2cm_seq #(
        .UNIT_COUNT_WIDTH(UNIT_COUNT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (r_in_item),
        .o_result    (w_step_res)
    );

    i2cm_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_data     (w_step_res),
        .i_ready    (m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .o_data     (w_out_res)
    );

    assign m_axis_tdata = {2'b00,
                           w_out_res.ack_missing,
                           w_out_res.rx_byte,
                           w_out_res.done_res,
                           w_out_res.busy_res,
                           w_out_res.sda_drive,
                           w_out_res.sda_level,
                           w_out_res.scl_level};

endmodule

// File: tb/tb_i2c_master_bit_sequencer_core.sv
// self-checking testbench for i2c_master_bit_sequencer_core: bus ticks in, pin levels out
// keeps its own tick-level model of the i2c sequencer and checks every result word
// depends on i2cm_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer_core;
    import i2cm_pkg::*;

    localparam int DLY_W = UNIT_COUNT_WIDTH_DEF + 2;

    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_STOP     = 3'd1,
        CMD_WRITE    = 3'd2,
        CMD_WAIT_ACK = 3'd3,
        CMD_READ     = 3'd4,
        CMD_UNUSED_5 = 3'd5,
        CMD_UNUSED_6 = 3'd6,
        CMD_UNUSED_7 = 3'd7
    } cmd_code_e;

    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C,
        SEQ_ACK_POLL, SEQ_WR_DATA, SEQ_WR_HIGH, SEQ_WR_LOW, SEQ_RD_LOW, SEQ_RD_HIGH,
        SEQ_AK_LOW, SEQ_AK_HIGH
    } seq_phase_e;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // model state
    seq_phase_e              ph;
    logic [3:0]              bit_cnt;
    logic [7:0]              shreg;
    logic [DLY_W-1:0]        dly;
    logic [ACK_TIMEOUT_W-1:0] polls;
    logic                    scl, sda, sda_oe, ack_sel, ack_lost;
    logic [7:0]              rx_last;
    logic [UNIT_TICKS_W-1:0] cfg_unit;
    logic [ACK_TIMEOUT_W-1:0] cfg_timeout;

    t_result                 expected_q[$];
    int                      err_count = 0;
    int                      ticks_sent = 0;
    int                      burst_left = 0;
    bit                      pace_en = 1'b1;
    bit                      long_hold = 1'b0;
    logic [15:0]             stall_mask;
    logic [3:0]              stall_slot;

    i2c_master_bit_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("i2c_master_bit_sequencer_core regression: fail");
        $finish;
    end

    function automatic logic [DLY_W-1:0] unit_span(input int n);
        logic [DLY_W-1:0] u;
        u = (cfg_unit == '0) ? DLY_W'(1) : DLY_W'(cfg_unit);
        return u * DLY_W'(n);
    endfunction

    function automatic void move_to(input seq_phase_e nxt, input logic [DLY_W-1:0] d);
        ph  = nxt;
        dly = d;
    endfunction

    function automatic void open_stop();
        sda_oe = 1'b1;
        scl    = 1'b0;
        sda    = 1'b0;
        move_to(SEQ_STOP_A, unit_span(4));
    endfunction

    function automatic void seq_reset();
        cfg_unit    = UNIT_TICKS_RESET;
        cfg_timeout = ACK_TIMEOUT_RESET;
        ph          = SEQ_IDLE;
        bit_cnt     = '0;
        shreg       = '0;
        dly         = '0;
        polls       = '0;
        scl         = 1'b1;
        sda         = 1'b1;
        sda_oe      = 1'b1;
        ack_sel     = 1'b0;
        rx_last     = '0;
        ack_lost    = 1'b0;
    endfunction

    // one bus tick of the sequencer, returns the pin and status word after the update
    function automatic t_result bus_tick(input t_item it);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (ph == SEQ_IDLE) begin
            if (it.cmd_valid) begin
                case (cmd_code_e'(it.command))
                    CMD_START: begin
                        sda_oe = 1'b1; sda = 1'b1; scl = 1'b1;
                        move_to(SEQ_START_A, unit_span(4));
                    end
                    CMD_STOP: open_stop();
                    CMD_WRITE: begin
                        sda_oe  = 1'b1; scl = 1'b0;
                        bit_cnt = '0;
                        sda     = it.tx_byte[7];
                        shreg   = {it.tx_byte[6:0], 1'b0};
                        move_to(SEQ_WR_DATA, unit_span(2));
                    end
                    CMD_WAIT_ACK: begin
                        sda_oe = 1'b0; sda = 1'b1; scl = 1'b1;
                        polls  = '0;
                        move_to(SEQ_ACK_POLL, '0);
                    end
                    CMD_READ: begin
                        sda_oe  = 1'b0; scl = 1'b0;
                        bit_cnt = '0; shreg = '0;
                        ack_sel = it.send_ack;
                        move_to(SEQ_RD_LOW, unit_span(2));
                    end
                    default: ;
                endcase
            end
        end else if (ph == SEQ_ACK_POLL) begin
            if (!it.sda_sample) begin
                scl      = 1'b0;
                ack_lost = 1'b0;
                move_to(SEQ_IDLE, '0);
                fin      = 1'b1;
            end else if (polls >= cfg_timeout) begin
                ack_lost = 1'b1;
                open_stop();
            end else begin
                polls = polls + 1'b1;
            end
        end else if (dly > 1) begin
            dly = dly - 1'b1;
        end else begin
            case (ph)
                SEQ_START_A: begin sda = 1'b0; move_to(SEQ_START_B, unit_span(4)); end
                SEQ_START_B: begin scl = 1'b0; move_to(SEQ_IDLE, '0); fin = 1'b1; end
                // scl rises a single tick ahead of sda
                SEQ_STOP_A:  begin scl = 1'b1; move_to(SEQ_STOP_B, DLY_W'(1)); end
                SEQ_STOP_B:  begin sda = 1'b1; move_to(SEQ_STOP_C, unit_span(4)); end
                SEQ_STOP_C:  begin move_to(SEQ_IDLE, '0); fin = 1'b1; end
                SEQ_WR_DATA: begin scl = 1'b1; move_to(SEQ_WR_HIGH, unit_span(2)); end
                SEQ_WR_HIGH: begin scl = 1'b0; move_to(SEQ_WR_LOW, unit_span(2)); end
                SEQ_WR_LOW: begin
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= 4'd8) begin
                        move_to(SEQ_IDLE, '0);
                        fin = 1'b1;
                    end else begin
                        sda   = shreg[7];
                        shreg = {shreg[6:0], 1'b0};
                        move_to(SEQ_WR_DATA, unit_span(2));
                    end
                end
                SEQ_RD_LOW: begin
                    scl     = 1'b1;
                    shreg   = {shreg[6:0], it.sda_sample};
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= 4'd8)
                        rx_last = shreg;
                    move_to(SEQ_RD_HIGH, unit_span(1));
                end
                SEQ_RD_HIGH: begin
                    scl = 1'b0;
                    if (bit_cnt >= 4'd8) begin
                        sda_oe = 1'b1;
                        sda    = ~ack_sel;
                        move_to(SEQ_AK_LOW, unit_span(2));
                    end else begin
                        move_to(SEQ_RD_LOW, unit_span(2));
                    end
                end
                SEQ_AK_LOW:  begin scl = 1'b1; move_to(SEQ_AK_HIGH, unit_span(2)); end
                SEQ_AK_HIGH: begin scl = 1'b0; move_to(SEQ_IDLE, '0); fin = 1'b1; end
                default:     move_to(SEQ_IDLE, '0);
            endcase
        end
        r.scl_level   = scl;
        r.sda_level   = sda;
        r.sda_drive   = sda_oe;
        r.busy_res    = (ph != SEQ_IDLE);
        r.done_res    = fin;
        r.rx_byte     = rx_last;
        r.ack_missing = ack_lost;
        return r;
    endfunction

    // scoreboard: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        t_item   seen;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            seq_reset();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_UNIT_TICKS)
                    cfg_unit = i_cfg_data[UNIT_TICKS_W-1:0];
                else
                    cfg_timeout = i_cfg_data[ACK_TIMEOUT_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.cmd_valid  = s_axis_tdata[0];
                seen.command    = s_axis_tdata[3:1];
                seen.tx_byte    = s_axis_tdata[11:4];
                seen.send_ack   = s_axis_tdata[12];
                seen.sda_sample = s_axis_tdata[13];
                expected_q.push_back(bus_tick(seen));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.scl_level   = m_axis_tdata[0];
                got.sda_level   = m_axis_tdata[1];
                got.sda_drive   = m_axis_tdata[2];
                got.busy_res    = m_axis_tdata[3];
                got.done_res    = m_axis_tdata[4];
                got.rx_byte     = m_axis_tdata[12:5];
                got.ack_missing = m_axis_tdata[13];
                if (expected_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result word with nothing expected: %h", $time,
                                 m_axis_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: mismatch scl/sda/oe/busy/done/rx/nack expected %b %b %b %b %b %h %b",
                                     $time, want.scl_level, want.sda_level, want.sda_drive,
                                     want.busy_res, want.done_res, want.rx_byte,
                                     want.ack_missing);
                            $display("%0t: mismatch scl/sda/oe/busy/done/rx/nack got      %b %b %b %b %b %h %b",
                                     $time, got.scl_level, got.sda_level, got.sda_drive,
                                     got.busy_res, got.done_res, got.rx_byte,
                                     got.ack_missing);
                        end
                    end
                end
            end
        end
    end

    // result side: stall pattern, always ready when pacing is off and no long hold is asked, or a long hold when asked
    initial begin
        m_axis_tready = 1'b0;
        stall_mask    = 16'hFFFF;
        stall_slot    = '0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!pace_en) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= stall_mask[stall_slot];
                stall_slot = stall_slot + 1'b1;
                if (stall_slot == '0)
                    stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
        end
    end

    // entered and left on a falling edge
    task automatic send_tick(input t_item it);
        int gap;
        if (pace_en) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.sda_sample, it.send_ack, it.tx_byte, it.command,
                          it.cmd_valid};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // issue one command, then tick until the sequencer is idle again
    // ack_after: high polls before the slave pulls sda low, negative never
    // sda_fill: sda level on other busy ticks, negative random
    task automatic run_cmd(input cmd_code_e code, input logic [7:0] data, input logic ack_bit,
                           input int ack_after, input int sda_fill);
        t_item it;
        int    highs;
        highs         = 0;
        it.cmd_valid  = 1'b1;
        it.command    = code;
        it.tx_byte    = data;
        it.send_ack   = ack_bit;
        it.sda_sample = 1'($urandom);
        send_tick(it);
        while (ph != SEQ_IDLE) begin
            it.cmd_valid = 1'($urandom);
            it.command   = 3'($urandom_range(0, 7));
            it.tx_byte   = 8'($urandom);
            it.send_ack  = 1'($urandom);
            if (ph == SEQ_ACK_POLL) begin
                it.sda_sample = (ack_after < 0) || (highs < ack_after);
                highs++;
            end else if (sda_fill < 0) begin
                it.sda_sample = 1'($urandom);
            end else begin
                it.sda_sample = sda_fill[0];
            end
            send_tick(it);
        end
    endtask

    function automatic int slave_ack_delay();
        return ($urandom_range(0, 3) == 0) ? -1 : int'($urandom_range(0, cfg_timeout));
    endfunction

    task automatic test_after_reset;
        run_cmd(CMD_START, 8'h00, 1'b0, 0, -1);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 3, -1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, 0, -1);
    endtask

    task automatic test_edge_fields;
        t_item it;
        write_reg(REG_UNIT_TICKS, 16'd1);
        it         = '0;
        it.command = CMD_WRITE;
        it.tx_byte = 8'hFF;
        send_tick(it);
        run_cmd(CMD_WRITE, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b1, 0, 1);
        run_cmd(CMD_READ, 8'h00, 1'b1, 0, 0);
        run_cmd(CMD_READ, 8'hFF, 1'b0, 0, 1);
        run_cmd(CMD_WAIT_ACK, 8'h5A, 1'b1, 0, -1);
        // full timeout at the reset limit
        run_cmd(CMD_WAIT_ACK, 8'hA5, 1'b0, -1, -1);
        run_cmd(CMD_UNUSED_5, 8'hFF, 1'b1, 0, 1);
        run_cmd(CMD_UNUSED_6, 8'h00, 1'b0, 0, 0);
        run_cmd(CMD_UNUSED_7, 8'hFF, 1'b1, 0, 1);
    endtask

    task automatic test_zero_settings;
        write_reg(REG_UNIT_TICKS, 16'd0);
        run_cmd(CMD_WRITE, 8'h3C, 1'b0, 0, -1);
        run_cmd(CMD_READ, 8'h00, 1'b1, 0, -1);
        write_reg(REG_ACK_TIMEOUT, 16'd0);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, -1, -1);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0, -1);
    endtask

    task automatic test_timeout_limits;
        write_reg(REG_UNIT_TICKS, 16'd1);
        // bits above the timeout field are dropped, leaving a limit of five
        write_reg(REG_ACK_TIMEOUT, 16'hFC05);
        // ack on the poll that would otherwise time out, then a full timeout
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 5, -1);
        run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, -1, -1);
    endtask

    task automatic test_slow_unit;
        pace_en = 1'b0;
        write_reg(REG_UNIT_TICKS, 16'd12);
        run_cmd(CMD_START, 8'h00, 1'b0, 0, -1);
        pace_en = 1'b1;
    endtask

    task automatic test_backpressure;
        write_reg(REG_UNIT_TICKS, 16'd2);
        pace_en   = 1'b0;
        long_hold = 1'b1;
        run_cmd(CMD_WRITE, 8'h96, 1'b0, 0, -1);
        run_cmd(CMD_READ, 8'h00, 1'b0, 0, -1);
        pace_en = 1'b1;
    endtask

    task automatic test_random_traffic;
        int ops;
        while (ticks_sent < 1260) begin
            write_reg(REG_UNIT_TICKS, 16'($urandom_range(1, 2)));
            write_reg(REG_ACK_TIMEOUT, 16'($urandom_range(0, 10)));
            if ($urandom_range(0, 9) < 7) begin
                // a well-formed transfer: start, address, acks, data, stop
                run_cmd(CMD_START, 8'($urandom), 1'($urandom), 0, -1);
                run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0, -1);
                run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom), slave_ack_delay(), -1);
                ops = $urandom_range(1, 3);
                repeat (ops) begin
                    if ($urandom_range(0, 1) == 0) begin
                        run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 0, -1);
                        run_cmd(CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
                                slave_ack_delay(), -1);
                    end else begin
                        run_cmd(CMD_READ, 8'($urandom), 1'($urandom), 0, -1);
                    end
                end
                run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 0, -1);
            end else begin
                run_cmd(cmd_code_e'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                        slave_ack_delay(), -1);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_after_reset();
        test_edge_fields();
        test_zero_settings();
        test_timeout_limits();
        test_slow_unit();
        test_backpressure();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (err_count == 0)
            $display("i2c_master_bit_sequencer_core regression: pass");
        else
            $display("i2c_master_bit_sequencer_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/i2cm_pkg.sv
src/i2cm_seq.sv
src/i2cm_out_reg.sv
src/i2c_master_bit_sequencer_core.sv
tb/tb_i2c_master_bit_sequencer_core.sv
